>>> src/controller_pak_command_engine_core_defines.svh
// Assertion macros shared by the controller-pak command engine.
`ifndef CONTROLLER_PAK_COMMAND_ENGINE_CORE_DEFINES_SVH
`define CONTROLLER_PAK_COMMAND_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CPCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cpce: implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CPCE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cpce: next-cycle check failed");

`endif

>>> src/cpce_pkg.sv
// Package with constants, types and CRC functions of the controller-pak command engine.
package cpce_pkg;

	localparam int BLOCK_BYTES = 32;
	localparam int PORT_COUNT  = 4;
	localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);
	localparam int PADDR_W     = 3;

	localparam logic [7:0]  CRC_POLY    = 8'h85;
	localparam logic [7:0]  OP_READ     = 8'h02;
	localparam logic [7:0]  OP_WRITE    = 8'h03;
	localparam logic [7:0]  FILL_BYTE   = 8'h80;
	localparam logic [15:0] ADDR_MASK   = 16'hFFE0;
	localparam logic [15:0] FILL_LO     = 16'h8000;
	localparam logic [15:0] FILL_HI     = 16'h9000;
	localparam logic [15:0] RUMBLE_ADDR = 16'hC000;
	localparam logic [4:0]  LAST_IDX    = 5'((BLOCK_BYTES - 1) & 31);

	typedef enum logic {
		REG_RAW_MASK = 1'b0,
		REG_RUMBLE   = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [PORT_COUNT-1:0] raw_port_mask;
		logic                  rumble_present;
	} cfg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_crc;
		logic       last;
		logic       rumble_valid;
		logic [1:0] rumble_port;
		logic       rumble_on;
	} result_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] cnt;
	} status_t;

	// One byte through the CRC register, MSB first, message bits shifted in.
	function automatic logic [7:0] crc_shift_byte(logic [7:0] rem, logic [7:0] b);
		logic [7:0] r;
		logic       hb;
		r = rem;
		for (int i = 7; i >= 0; i--) begin
			hb = r[7];
			r  = {r[6:0], b[i]};
			if (hb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	// CRC of a whole block of one repeated byte, augmented; used for constants only.
	function automatic logic [7:0] fill_crc(logic [7:0] fill);
		logic [7:0] r;
		r = 8'h00;
		for (int k = 0; k < BLOCK_BYTES; k++) begin
			r = crc_shift_byte(r, fill);
		end
		return crc_shift_byte(r, 8'h00);
	endfunction

	localparam logic [7:0] FILL_CRC = fill_crc(FILL_BYTE);
	localparam logic [7:0] ZERO_CRC = fill_crc(8'h00);

endpackage

>>> src/cpce_if.sv
// Command and result channel interfaces of the controller-pak command engine.
interface cpce_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] opcode;
	logic [1:0] port;
	logic [15:0] pak_address;
	logic [4:0] byte_index;
	logic [7:0] data_byte;

	modport source (output valid, opcode, port, pak_address, byte_index, data_byte,
		input ready);
	modport sink (input valid, opcode, port, pak_address, byte_index, data_byte,
		output ready);
endinterface

interface cpce_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_crc;
	logic       last;
	logic       rumble_valid;
	logic [1:0] rumble_port;
	logic       rumble_on;

	modport source (output valid, out_byte, is_crc, last, rumble_valid, rumble_port,
		rumble_on, input ready);
	modport sink (input valid, out_byte, is_crc, last, rumble_valid, rumble_port,
		rumble_on, output ready);
endinterface

>>> src/controller_pak_command_engine_core.sv
// A command is registered on transfer; its results wait for a free result register.
// Throughput: one write byte per cycle, but the last byte of a block waits for the result
// register; a read holds the input register for 33 result transfers (32 fill bytes and the
// CRC), counted by the read burst counter. Commands with no result retire without waiting.
// Reset: raw_port_mask clears, rumble_present sets, the pipeline empties, CRC state clears.
`include "controller_pak_command_engine_core_defines.svh"

module controller_pak_command_engine_core (
	input  logic                         clk,
	input  logic                         arst_n,
	cpce_cmd_if.sink                     cmd,
	cpce_res_if.source                   res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cpce_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	cpce_pkg::cfg_t    cfg;
	cpce_pkg::status_t st;

	cpce_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cpce_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.res    (res),
		.st     (st)
	);

	`CPCE_ASSERT_IMP(a_rumble_on_crc, clk, arst_n, res.valid && res.rumble_valid, res.is_crc && res.last)
	`CPCE_ASSERT_IMP(a_crc_is_last, clk, arst_n, res.valid, res.is_crc == res.last)
	`CPCE_ASSERT_IMP(a_rumble_quiet, clk, arst_n, res.valid && !res.rumble_valid, res.rumble_port == 2'd0 && !res.rumble_on)
	`CPCE_ASSERT_NXT(a_res_held, clk, arst_n, res.valid && !res.ready, res.valid && $stable(res.out_byte))
	`CPCE_ASSERT_IMP(a_cnt_needs_item, clk, arst_n, st.cnt != '0, st.busy)

endmodule

>>> src/cpce_apb_regs.sv
// APB configuration registers: raw port mask and rumble enable.
module cpce_apb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cpce_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output cpce_pkg::cfg_t             cfg
);

	logic [cpce_pkg::PORT_COUNT-1:0]     mask_q;
	logic                                rumble_q;
	logic                                wr_en;
	cpce_pkg::reg_idx_t                  sel;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign sel    = cpce_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= '0;
			rumble_q <= 1'b1;
		end else if (wr_en) begin
			unique case (sel)
				cpce_pkg::REG_RAW_MASK: mask_q   <= pwdata[cpce_pkg::PORT_COUNT-1:0];
				cpce_pkg::REG_RUMBLE:   rumble_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			cpce_pkg::REG_RAW_MASK: prdata = {{(32 - cpce_pkg::PORT_COUNT){1'b0}}, mask_q};
			cpce_pkg::REG_RUMBLE:   prdata = {31'd0, rumble_q};
			default:                prdata = '0;
		endcase
	end

	assign cfg.raw_port_mask  = mask_q;
	assign cfg.rumble_present = rumble_q;

endmodule

>>> src/cpce_engine.sv
// Command datapath: input register, write CRC state, read burst counter, result register.
module cpce_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  cpce_pkg::cfg_t     cfg,
	cpce_cmd_if.sink           cmd,
	cpce_res_if.source         res,
	output cpce_pkg::status_t  st
);

	logic                         valid_s1;
	logic [7:0]                   opcode_s1;
	logic [1:0]                   port_s1;
	logic [15:0]                  addr_s1;
	logic [4:0]                   idx_s1;
	logic [7:0]                   data_s1;

	logic [cpce_pkg::CNT_W-1:0]   cnt_q;
	logic [7:0]                   crc_q;
	logic                         fbn_q;
	logic                         out_valid_q;
	cpce_pkg::result_t            out_q;

	logic       port_ok;
	logic       is_rd;
	logic       is_wr;
	logic       wr_last;
	logic       emits;
	logic       load_ok;
	logic       burst_end;
	logic       retire;
	logic       out_load;
	logic       in_fire;
	logic [7:0] crc_base;
	logic [7:0] crc_next;
	logic       fbn_next;
	logic [7:0] wr_crc;
	logic       fill_range;
	logic       rumble_hit;
	cpce_pkg::result_t res_next;

	assign port_ok    = cfg.raw_port_mask[port_s1] && (int'(port_s1) < cpce_pkg::PORT_COUNT);
	assign is_rd      = valid_s1 && port_ok && (opcode_s1 == cpce_pkg::OP_READ);
	assign is_wr      = valid_s1 && port_ok && (opcode_s1 == cpce_pkg::OP_WRITE)
		&& (idx_s1 <= cpce_pkg::LAST_IDX);
	assign wr_last    = is_wr && (idx_s1 == cpce_pkg::LAST_IDX);
	assign emits      = is_rd || wr_last;
	assign load_ok    = !out_valid_q || res.ready;
	assign burst_end  = (cnt_q == cpce_pkg::CNT_W'(cpce_pkg::BLOCK_BYTES));
	// A read stays in the input register until its CRC transfer is loaded.
	assign retire     = valid_s1 && (!emits || (load_ok && (wr_last || burst_end)));
	assign out_load   = emits && load_ok;
	assign cmd.ready  = !valid_s1 || retire;
	assign in_fire    = cmd.valid && cmd.ready;

	assign crc_base   = (idx_s1 == 5'd0) ? 8'h00 : crc_q;
	assign crc_next   = cpce_pkg::crc_shift_byte(crc_base, data_s1);
	assign fbn_next   = (idx_s1 == 5'd0) ? (data_s1 != 8'h00) : fbn_q;
	assign wr_crc     = cpce_pkg::crc_shift_byte(crc_next, 8'h00);
	assign fill_range = (addr_s1 >= cpce_pkg::FILL_LO) && (addr_s1 < cpce_pkg::FILL_HI);
	assign rumble_hit = cfg.rumble_present && (addr_s1 == cpce_pkg::RUMBLE_ADDR);

	always_comb begin
		res_next = '0;
		if (is_rd) begin
			if (burst_end) begin
				res_next.out_byte = fill_range ? cpce_pkg::FILL_CRC : cpce_pkg::ZERO_CRC;
			end else begin
				res_next.out_byte = fill_range ? cpce_pkg::FILL_BYTE : 8'h00;
			end
			res_next.is_crc = burst_end;
			res_next.last   = burst_end;
		end else begin
			res_next.out_byte     = wr_crc;
			res_next.is_crc       = 1'b1;
			res_next.last         = 1'b1;
			res_next.rumble_valid = rumble_hit;
			res_next.rumble_port  = rumble_hit ? port_s1 : 2'd0;
			res_next.rumble_on    = rumble_hit && fbn_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			cnt_q       <= '0;
			crc_q       <= 8'h00;
			fbn_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (retire) begin
				valid_s1 <= 1'b0;
			end
			if (retire && is_wr) begin
				crc_q <= crc_next;
				fbn_q <= fbn_next;
			end
			if (is_rd && out_load) begin
				cnt_q <= burst_end ? '0 : cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			opcode_s1 <= cmd.opcode;
			port_s1   <= cmd.port;
			addr_s1   <= cmd.pak_address & cpce_pkg::ADDR_MASK;
			idx_s1    <= cmd.byte_index;
			data_s1   <= cmd.data_byte;
		end
		if (out_load) begin
			out_q <= res_next;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.out_byte     = out_q.out_byte;
	assign res.is_crc       = out_q.is_crc;
	assign res.last         = out_q.last;
	assign res.rumble_valid = out_q.rumble_valid;
	assign res.rumble_port  = out_q.rumble_port;
	assign res.rumble_on    = out_q.rumble_on;

	assign st.busy = valid_s1;
	assign st.cnt  = cnt_q;

endmodule
